// ===== hw/rtl/ckx_pkg.sv =====
// Package for the chained-key XOR string cipher.
// Opcodes, register indexes, element types and masks shared by the interface, element unit, top level and checker.
// No dependencies.
package ckx_pkg;

  localparam int ELEM_W = 16;

  typedef logic [ELEM_W-1:0] elem_t;

  // Element masks for the two element widths
  localparam elem_t ELEM_MASK_WIDE   = 16'hFFFF;
  localparam elem_t ELEM_MASK_NARROW = 16'h00FF;

  // Input item opcodes; the remaining code is ignored
  typedef enum logic [1:0] {
    OP_NEW_KEY    = 2'd0,
    OP_APPEND_KEY = 2'd1,
    OP_DATA       = 2'd2
  } opcode_t;

  // Configuration register indexes
  typedef enum logic {
    CFG_DIRECTION = 1'b0,
    CFG_WIDE_MODE = 1'b1
  } cfg_index_t;

  // Controls for the element datapath
  typedef struct packed {
    logic decrypt;
    logic wide;
    logic key_missing;
    logic pos_lsb;
  } elem_ctrl_t;

endpackage

// ===== hw/rtl/ckx_if.sv =====
// Stream interfaces for the cipher: request items in, result items out.
// Depends on ckx_pkg.
interface ckx_in_if;
  import ckx_pkg::*;

  logic          valid;
  logic          ready;
  opcode_t       opcode;
  logic [15:0]   data_value;
  logic          end_of_string;

  modport source (output valid, output opcode, output data_value, output end_of_string,
                  input ready);
  modport sink   (input valid, input opcode, input data_value, input end_of_string,
                  output ready);
endinterface

interface ckx_out_if;
  logic          valid;
  logic          ready;
  logic [15:0]   result_value;
  logic          result_last;
  logic          key_missing;

  modport source (output valid, output result_value, output result_last, output key_missing,
                  input ready);
  modport sink   (input valid, input result_value, input result_last, input key_missing,
                  output ready);
endinterface

// ===== hw/rtl/ckx_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ckx_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port (returns old data on a same-address write)
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/ckx_elem_unit.sv =====
// Element datapath: one encrypt or decrypt step on a single element.
// Depends on ckx_pkg.
module ckx_elem_unit
  import ckx_pkg::*;
(
  input  ckx_pkg::elem_ctrl_t ctrl,
  input  ckx_pkg::elem_t      value,
  input  ckx_pkg::elem_t      key_elem,
  input  ckx_pkg::elem_t      last,
  output ckx_pkg::elem_t      result,
  output ckx_pkg::elem_t      plain
);

  elem_t mask;
  elem_t xm, km, lm;
  elem_t mix;
  elem_t enc_r;
  elem_t dec_t;
  elem_t dec_r;
  logic  odd;

  // Everything wraps at 16 bits; the low bits never depend on the high ones,
  // so masking the operands and the final value is enough for narrow mode.
  always_comb begin
    mask  = ctrl.wide ? ELEM_MASK_WIDE : ELEM_MASK_NARROW;
    xm    = value & mask;
    km    = key_elem & mask;
    lm    = last & mask;
    odd   = ctrl.pos_lsb & km[0];

    // encrypt
    mix   = xm ^ km;
    enc_r = odd ? (((-mix) ^ km) + lm) : (((~mix) ^ km) - lm);

    // decrypt
    dec_t = odd ? (-((xm - lm) ^ km)) : (~((xm + lm) ^ km));
    dec_r = dec_t ^ km;

    if (ctrl.key_missing) begin
      result = xm;
    end else begin
      result = (ctrl.decrypt ? dec_r : enc_r) & mask;
    end
    plain = ctrl.decrypt ? result : xm;
  end

endmodule

// ===== hw/rtl/chained_key_xor_string_cipher_unit.sv =====
// Top level of the chained-key XOR string cipher.
// Depends on ckx_pkg, ckx_if, ckx_ram and ckx_elem_unit.
//
// Takes one request item per cycle, unless a stalled result holds it, and returns a
// result for every data item through the input register, then key lookup and element
// step into the result register. Key items give no result. The rate is one item per
// cycle, set by the update of key position and previous element as each item
// executes; the key store RAM is read in the cycle before, at the position the next
// item will use, with a bypass for an element written in that same cycle. The key
// store needs no clearing pass: only entries below the key count are read. A stalled
// result holds the pipeline only when the next item is a data item.
module chained_key_xor_string_cipher_unit #(
  parameter int KEY_DEPTH = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  ckx_pkg::cfg_index_t  cfg_index,
  input  logic                 cfg_data,
  ckx_in_if.sink               request,
  ckx_out_if.source            response
);
  import ckx_pkg::*;

  localparam int CNT_W  = $clog2(KEY_DEPTH + 1);
  localparam int ADDR_W = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;

  // configuration
  logic direction;
  logic wide_mode;

  // input register
  logic    s1_valid;
  opcode_t s1_opcode;
  elem_t   s1_value;
  logic    s1_eos;

  // cipher state
  logic [CNT_W-1:0]  key_count, key_count_next;
  logic [ADDR_W-1:0] key_position, key_position_next;
  elem_t             previous_plain, previous_plain_next;
  logic [CNT_W-1:0]  pos_inc;

  // key store access
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  elem_t             ram_rdata;
  logic              byp_hit, byp_hit_next;
  elem_t             byp_data;
  elem_t             key_elem;

  logic       fire;
  logic       load_result;
  logic       key_missing;
  elem_ctrl_t elem_ctrl;
  elem_t      elem_result;
  elem_t      elem_plain;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      direction <= 1'b0;
      wide_mode <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_DIRECTION: direction <= cfg_data;
        CFG_WIDE_MODE: wide_mode <= cfg_data;
      endcase
    end
  end

  // Execute when the item needs no result slot or the slot is free or draining
  assign fire = s1_valid &&
                ((s1_opcode != OP_DATA) || !response.valid || response.ready);
  assign request.ready = !s1_valid || fire;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (request.ready) begin
      s1_valid <= request.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (request.valid && request.ready) begin
      s1_opcode <= request.opcode;
      s1_value  <= request.data_value;
      s1_eos    <= request.end_of_string;
    end
  end

  // Key element for the item in the input register
  assign key_elem    = byp_hit ? byp_data : ram_rdata;
  assign key_missing = (key_count == '0);

  always_comb begin
    elem_ctrl.decrypt     = direction;
    elem_ctrl.wide        = wide_mode;
    elem_ctrl.key_missing = key_missing;
    elem_ctrl.pos_lsb     = key_position[0];
  end

  ckx_elem_unit u_elem (
    .ctrl     (elem_ctrl),
    .value    (s1_value),
    .key_elem (key_elem),
    .last     (previous_plain),
    .result   (elem_result),
    .plain    (elem_plain)
  );

  // Next state of the key store and the chain
  assign pos_inc = CNT_W'(key_position) + CNT_W'(1);

  always_comb begin
    key_count_next      = key_count;
    key_position_next   = key_position;
    previous_plain_next = previous_plain;
    ram_we              = 1'b0;
    ram_waddr           = '0;
    load_result         = 1'b0;
    if (fire) begin
      unique case (s1_opcode)
        OP_NEW_KEY: begin
          ram_we              = 1'b1;
          key_count_next      = CNT_W'(1);
          key_position_next   = '0;
          previous_plain_next = '0;
        end
        OP_APPEND_KEY: begin
          if (key_count < CNT_W'(KEY_DEPTH)) begin
            ram_we         = 1'b1;
            ram_waddr      = key_count[ADDR_W-1:0];
            key_count_next = key_count + CNT_W'(1);
          end
        end
        OP_DATA: begin
          load_result = 1'b1;
          if (!key_missing) begin
            key_position_next   = (pos_inc >= key_count) ? '0 : pos_inc[ADDR_W-1:0];
            previous_plain_next = elem_plain;
          end
          if (s1_eos) begin
            key_position_next   = '0;
            previous_plain_next = '0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_count      <= '0;
      key_position   <= '0;
      previous_plain <= '0;
    end else begin
      key_count      <= key_count_next;
      key_position   <= key_position_next;
      previous_plain <= previous_plain_next;
    end
  end

  // Key store, read ahead at the next position
  ckx_ram #(
    .WIDTH (ELEM_W),
    .DEPTH (KEY_DEPTH)
  ) u_key_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (s1_value),
    .raddr (key_position_next),
    .rdata (ram_rdata)
  );

  // Bypass for a write to the entry being read in the same cycle
  assign byp_hit_next = ram_we && (ram_waddr == key_position_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      byp_hit <= 1'b0;
    end else begin
      byp_hit <= byp_hit_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ram_we) begin
      byp_data <= s1_value;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      response.valid <= 1'b0;
    end else if (load_result) begin
      response.valid <= 1'b1;
    end else if (response.ready) begin
      response.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_result) begin
      response.result_value <= elem_result;
      response.result_last  <= s1_eos;
      response.key_missing  <= key_missing;
    end
  end

endmodule

// ===== hw/rtl/ckx_checker.sv =====
// Port-level checks for the cipher top level, attached by bind.
// Depends on ckx_pkg and chained_key_xor_string_cipher_unit.
module ckx_checker
  import ckx_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                cfg_write,
  input ckx_pkg::cfg_index_t cfg_index,
  input logic                cfg_data,
  input logic                req_ready,
  input logic                rsp_valid,
  input logic                rsp_ready,
  input logic [15:0]         rsp_value,
  input logic                rsp_last,
  input logic                rsp_key_missing
);

  // Shadow of the element width register
  logic wide;

  always_ff @(posedge clk) begin
    if (rst) begin
      wide <= 1'b0;
    end else if (cfg_write && (cfg_index == CFG_WIDE_MODE)) begin
      wide <= cfg_data;
    end
  end

  // Reset empties the pipeline: no result, ready for a transfer
  a_reset_no_result: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("result valid after reset");

  a_reset_ready: assert property (@(posedge clk) rst |=> req_ready)
    else $error("request not ready after reset");

  // Narrow mode results stay within 8 bits
  a_narrow_mask: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !wide) |-> (rsp_value[15:8] == 8'h00))
    else $error("narrow result not masked");

  // A stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=>
      (rsp_valid && $stable(rsp_value) && $stable(rsp_last) && $stable(rsp_key_missing)))
    else $error("stalled result changed");

endmodule

bind chained_key_xor_string_cipher_unit ckx_checker u_ckx_checker (
  .clk             (clk),
  .rst             (rst),
  .cfg_write       (cfg_write),
  .cfg_index       (cfg_index),
  .cfg_data        (cfg_data),
  .req_ready       (request.ready),
  .rsp_valid       (response.valid),
  .rsp_ready       (response.ready),
  .rsp_value       (response.result_value),
  .rsp_last        (response.result_last),
  .rsp_key_missing (response.key_missing)
);
